FILE: design/assert_macros.svh
// Assertion macros shared by the line assembler RTL.
// Bodies compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SLA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define SLA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define SLA_ASSERT(label, clk, rst, prop, msg)
`define SLA_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`endif
`endif

FILE: design/sla_pkg.sv
// Types and constants for the serial line assembler.
// No dependencies; used by sla_store and serial_line_assembler.
package sla_pkg;

   localparam int unsigned MAX_LINE = 64;
   localparam int unsigned CNT_W = $clog2(MAX_LINE);
   localparam int unsigned BANK_DEPTH = 1 << CNT_W;
   localparam int unsigned STORE_DEPTH = 2 * BANK_DEPTH;
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_LINE - 1);

   localparam logic [7:0] BYTE_LF = 8'h0A;
   localparam logic [7:0] BYTE_CR = 8'h0D;

   localparam logic [1:0] KIND_BYTE = 2'd0;
   localparam logic [1:0] KIND_NONE = 2'd1;
   localparam logic [1:0] KIND_OVERFLOW = 2'd2;

   localparam logic MODE_BYTE = 1'b0;

   typedef struct packed {
      logic       mode;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic             wr_en;
      logic [CNT_W-1:0] wr_idx;
      logic [7:0]       wr_data;
      logic             swap;
      logic             rd_en;
      logic [CNT_W-1:0] rd_idx;
   } store_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_STREAM = 2'b10
   } state_type;

endpackage

FILE: design/sla_store.sv
// Two-bank line memory: one bank fills with the pending line, the other holds the ready line.
// Completing a line swaps the banks instead of copying. Depends on sla_pkg.
module sla_store (
   input  logic                  clock,
   input  logic                  reset,
   input  sla_pkg::store_ctl_type ctl,
   output logic [7:0]            rd_data
);

   logic [7:0] mem [sla_pkg::STORE_DEPTH];
   logic       bank_ff;
   logic       bank_in;
   logic [7:0] rd_data_ff;

   assign bank_in = ctl.swap ? ~bank_ff : bank_ff;
   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff <= 1'b0;
      end else begin
         bank_ff <= bank_in;
      end
   end

   // pending bank is bank_ff, ready bank is its complement
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[{bank_ff, ctl.wr_idx}] <= ctl.wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[{~bank_ff, ctl.rd_idx}];
      end
   end

endmodule

FILE: design/serial_line_assembler.sv
// Serial line assembler top level: line state control and result streaming.
// Depends on sla_pkg, sla_store and assert_macros.svh.
//
//   channel   ports                          transfer
//   request   start, busy, req_item          start high and busy low at a clock edge
//   result    rsp_strobe, rsp_item           rsp_strobe high for one cycle, always taken
//
// A take with no line, or a newline ending an oversized line, gives its single
// result in the cycle after the transfer. A take with a line ready enters the
// streaming state and holds busy there, one memory read per byte of the line;
// each byte appears in the cycle after its read, as the read port of the line
// memory is registered.
// Synchronous reset empties both lines and clears overflow; no clearing pass.
`include "assert_macros.svh"
module serial_line_assembler (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  sla_pkg::req_type req_item,
   output logic             rsp_strobe,
   output sla_pkg::rsp_type rsp_item
);

   localparam int unsigned CW = sla_pkg::CNT_W;

   sla_pkg::state_type     state_ff, state_in;
   logic [CW-1:0]          pending_count_ff, pending_count_in;
   logic [CW-1:0]          cr_run_ff, cr_run_in;
   logic [CW-1:0]          ready_count_ff, ready_count_in;
   logic                   overflow_ff, overflow_in;
   logic                   line_ready_ff, line_ready_in;
   logic [CW-1:0]          rd_idx_ff, rd_idx_in;
   logic                   rd_vld_ff, rd_vld_in;
   logic                   rd_last_ff, rd_last_in;
   logic                   evt_valid_ff, evt_valid_in;
   logic [1:0]             evt_kind_ff, evt_kind_in;
   sla_pkg::store_ctl_type ctl;
   logic [7:0]             rd_data;
   logic                   accept;
   logic                   stream_last;

   sla_store u_store (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .rd_data (rd_data)
   );

   assign busy = (state_ff == sla_pkg::ST_STREAM);
   assign accept = start & ~busy;
   assign stream_last = (rd_idx_ff == ready_count_ff - CW'(1));

   always_comb begin
      state_in = state_ff;
      pending_count_in = pending_count_ff;
      cr_run_in = cr_run_ff;
      ready_count_in = ready_count_ff;
      overflow_in = overflow_ff;
      line_ready_in = line_ready_ff;
      rd_idx_in = rd_idx_ff;
      rd_vld_in = 1'b0;
      rd_last_in = rd_last_ff;
      evt_valid_in = 1'b0;
      evt_kind_in = evt_kind_ff;
      ctl = '0;
      case (state_ff)
         sla_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_item.mode != sla_pkg::MODE_BYTE) begin
                  if (!line_ready_ff || ready_count_ff == '0) begin
                     evt_valid_in = 1'b1;
                     evt_kind_in = sla_pkg::KIND_NONE;
                  end else begin
                     state_in = sla_pkg::ST_STREAM;
                     rd_idx_in = '0;
                     line_ready_in = 1'b0;
                  end
               end else if (req_item.rx_byte != sla_pkg::BYTE_LF) begin
                  if (!overflow_ff) begin
                     if (pending_count_ff >= sla_pkg::FULL_COUNT) begin
                        overflow_in = 1'b1;
                        pending_count_in = '0;
                        cr_run_in = '0;
                     end else begin
                        ctl.wr_en = 1'b1;
                        ctl.wr_idx = pending_count_ff;
                        ctl.wr_data = req_item.rx_byte;
                        pending_count_in = pending_count_ff + CW'(1);
                        cr_run_in = (req_item.rx_byte == sla_pkg::BYTE_CR) ?
                                    cr_run_ff + CW'(1) : '0;
                     end
                  end
               end else begin
                  if (overflow_ff) begin
                     overflow_in = 1'b0;
                     evt_valid_in = 1'b1;
                     evt_kind_in = sla_pkg::KIND_OVERFLOW;
                  end else if (pending_count_ff != cr_run_ff) begin
                     ctl.swap = 1'b1;
                     ready_count_in = pending_count_ff - cr_run_ff;
                     line_ready_in = 1'b1;
                  end
                  pending_count_in = '0;
                  cr_run_in = '0;
               end
            end
         end
         sla_pkg::ST_STREAM: begin
            ctl.rd_en = 1'b1;
            ctl.rd_idx = rd_idx_ff;
            rd_vld_in = 1'b1;
            rd_last_in = stream_last;
            if (stream_last) begin
               state_in = sla_pkg::ST_IDLE;
            end else begin
               rd_idx_in = rd_idx_ff + CW'(1);
            end
         end
         default: begin
            state_in = sla_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sla_pkg::ST_IDLE;
         pending_count_ff <= '0;
         cr_run_ff <= '0;
         ready_count_ff <= '0;
         overflow_ff <= 1'b0;
         line_ready_ff <= 1'b0;
         rd_idx_ff <= '0;
         rd_vld_ff <= 1'b0;
         evt_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pending_count_ff <= pending_count_in;
         cr_run_ff <= cr_run_in;
         ready_count_ff <= ready_count_in;
         overflow_ff <= overflow_in;
         line_ready_ff <= line_ready_in;
         rd_idx_ff <= rd_idx_in;
         rd_vld_ff <= rd_vld_in;
         evt_valid_ff <= evt_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_last_ff <= rd_last_in;
      evt_kind_ff <= evt_kind_in;
   end

   assign rsp_strobe = rd_vld_ff | evt_valid_ff;

   always_comb begin
      if (rd_vld_ff) begin
         rsp_item.kind = sla_pkg::KIND_BYTE;
         rsp_item.data_byte = rd_data;
         rsp_item.last = rd_last_ff;
      end else begin
         rsp_item.kind = evt_kind_ff;
         rsp_item.data_byte = '0;
         rsp_item.last = 1'b1;
      end
   end

   `SLA_ASSERT(a_one_source, clock, reset, !(rd_vld_ff && evt_valid_ff), "result sources collide")
   `SLA_ASSERT_IMPL(a_ovf_empty, clock, reset, overflow_ff, pending_count_ff == '0, "pending kept")
   `SLA_ASSERT(a_cr_run, clock, reset, cr_run_ff <= pending_count_ff, "cr run too long")
   `SLA_ASSERT_IMPL(a_stream_idx, clock, reset, busy, rd_idx_ff < ready_count_ff, "index past end")
   `SLA_ASSERT_IMPL(a_no_write_busy, clock, reset, busy, !ctl.wr_en && !ctl.swap, "store written")

endmodule

FILE: bench/serial_line_assembler_tb.sv
// Testbench for serial_line_assembler: directed and random received-byte and take traffic.
// Each result is checked against an in-bench line model in transfer order.
// Depends on sla_pkg and the serial_line_assembler RTL.
module serial_line_assembler_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic MODE_TAKE   = 1'b1;
   localparam int   ITEM_TARGET = 370;
   localparam int   MAX_GAP     = 14;
   localparam int   IDLE_LIMIT  = 2000;

   typedef struct {
      sla_pkg::req_type req;
      int               gap;
      bit               drain;
   } stim_type;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             start      = 1'b0;
   sla_pkg::req_type req_item   = '0;
   logic             busy;
   logic             rsp_strobe;
   sla_pkg::rsp_type rsp_item;

   serial_line_assembler dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always #5 clock = ~clock;

   // line model state
   logic [7:0] pend_buf [sla_pkg::MAX_LINE];
   logic [7:0] line_buf [sla_pkg::MAX_LINE];
   int         pend_len     = 0;
   int         cr_run       = 0;
   int         line_len     = 0;
   bit         overflow     = 1'b0;
   bit         line_waiting = 1'b0;

   sla_pkg::rsp_type owed_rsp_q [$];
   stim_type   stim_q [$];
   stim_type   cur;
   bit         cur_valid   = 1'b0;
   int         gap_left    = 0;
   logic       took        = 1'b0;
   int         sent        = 0;
   int         total_items = 0;
   int         errors      = 0;
   int         idle_cycles = 0;
   int         counted     = 0;
   bit         no_idle     = 1'b0;

   function automatic sla_pkg::rsp_type make_rsp(logic [1:0] k, logic [7:0] d, logic l);
      sla_pkg::rsp_type r;
      r.kind      = k;
      r.data_byte = d;
      r.last      = l;
      return r;
   endfunction

   function automatic void assemble_line(sla_pkg::req_type r);
      int keep;
      if (r.mode == MODE_TAKE) begin
         if (!line_waiting || line_len == 0) begin
            owed_rsp_q.push_back(make_rsp(sla_pkg::KIND_NONE, 8'h00, 1'b1));
         end else begin
            for (int i = 0; i < line_len; i++)
               owed_rsp_q.push_back(make_rsp(sla_pkg::KIND_BYTE, line_buf[i],
                                             i == line_len - 1));
            line_waiting = 1'b0;
         end
      end else if (r.rx_byte != sla_pkg::BYTE_LF) begin
         if (!overflow) begin
            if (pend_len + 1 >= sla_pkg::MAX_LINE) begin
               overflow = 1'b1;
               pend_len = 0;
               cr_run   = 0;
            end else begin
               pend_buf[pend_len] = r.rx_byte;
               pend_len++;
               cr_run = (r.rx_byte == sla_pkg::BYTE_CR) ? cr_run + 1 : 0;
            end
         end
      end else if (overflow) begin
         overflow = 1'b0;
         pend_len = 0;
         cr_run   = 0;
         owed_rsp_q.push_back(make_rsp(sla_pkg::KIND_OVERFLOW, 8'h00, 1'b1));
      end else begin
         keep = pend_len - cr_run;
         if (keep > 0) begin
            for (int i = 0; i < keep; i++)
               line_buf[i] = pend_buf[i];
            line_len     = keep;
            line_waiting = 1'b1;
         end
         pend_len = 0;
         cr_run   = 0;
      end
   endfunction

   function automatic void log_mismatch(string what);
      errors++;
      if (errors <= 10)
         $display("%0t: %s", $realtime, what);
   endfunction

   task automatic add_item(logic m, logic [7:0] b, bit counts);
      stim_type s;
      s.req.mode    = m;
      s.req.rx_byte = b;
      s.gap         = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      s.drain       = ($urandom_range(0, 99) < 2);
      stim_q.push_back(s);
      if (counts)
         counted++;
   endtask

   // len content bytes, then trailing CRs, then newline
   task automatic add_line(int len, int trail_cr);
      logic [7:0] b;
      for (int i = 0; i < len; i++) begin
         b = 8'($urandom_range(0, 255));
         if ($urandom_range(0, 9) == 0)
            b = sla_pkg::BYTE_CR;
         if (b == sla_pkg::BYTE_LF)
            b = 8'h0B;
         add_item(sla_pkg::MODE_BYTE, b, i < sla_pkg::MAX_LINE);
      end
      for (int i = 0; i < trail_cr; i++)
         add_item(sla_pkg::MODE_BYTE, sla_pkg::BYTE_CR, 1'b1);
      add_item(sla_pkg::MODE_BYTE, sla_pkg::BYTE_LF, 1'b1);
   endtask

   // driver: inputs change on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && !took)) begin
         if (!cur_valid && stim_q.size() != 0) begin
            cur       = stim_q.pop_front();
            cur_valid = 1'b1;
            gap_left  = cur.gap;
         end
         if (cur_valid && gap_left == 0 && !(cur.drain && owed_rsp_q.size() != 0)) begin
            req_item  <= cur.req;
            start     <= 1'b1;
            cur_valid  = 1'b0;
         end else begin
            start <= 1'b0;
            if (cur_valid && gap_left > 0)
               gap_left--;
         end
      end
   end

   // monitor, checker and watchdog: sampled on the rising edge
   always @(posedge clock) begin
      sla_pkg::rsp_type want;
      took <= start && !busy;
      if (!reset) begin
         if (rsp_strobe) begin
            if (owed_rsp_q.size() == 0) begin
               log_mismatch($sformatf("unexpected result kind %0d byte %02h last %0b",
                  rsp_item.kind, rsp_item.data_byte, rsp_item.last));
            end else begin
               want = owed_rsp_q.pop_front();
               if (rsp_item.kind !== want.kind || rsp_item.data_byte !== want.data_byte ||
                   rsp_item.last !== want.last)
                  log_mismatch($sformatf(
                     "expected kind %0d byte %02h last %0b, got kind %0d byte %02h last %0b",
                     want.kind, want.data_byte, want.last,
                     rsp_item.kind, rsp_item.data_byte, rsp_item.last));
            end
         end
         if (start && !busy) begin
            assemble_line(req_item);
            sent++;
         end
         if (rsp_strobe || (start && !busy))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("serial_line_assembler: mismatch");
            $finish;
         end
      end
   end

   initial begin
      int pick;
      int len;

      // directed
      add_item(MODE_TAKE, 8'h00, 1'b1);
      add_item(sla_pkg::MODE_BYTE, 8'h00, 1'b1);
      add_item(sla_pkg::MODE_BYTE, 8'hFF, 1'b1);
      add_item(sla_pkg::MODE_BYTE, sla_pkg::BYTE_LF, 1'b1);
      add_item(MODE_TAKE, 8'hFF, 1'b1);
      stim_q[stim_q.size() - 1].drain = 1'b1;
      add_item(sla_pkg::MODE_BYTE, sla_pkg::BYTE_CR, 1'b1);
      add_item(sla_pkg::MODE_BYTE, sla_pkg::BYTE_LF, 1'b1);
      add_item(MODE_TAKE, 8'h00, 1'b1);
      add_item(sla_pkg::MODE_BYTE, 8'h41, 1'b1);
      add_item(sla_pkg::MODE_BYTE, sla_pkg::BYTE_LF, 1'b1);
      add_item(sla_pkg::MODE_BYTE, 8'h42, 1'b1);
      add_item(sla_pkg::MODE_BYTE, sla_pkg::BYTE_CR, 1'b1);
      add_item(sla_pkg::MODE_BYTE, sla_pkg::BYTE_CR, 1'b1);
      add_item(sla_pkg::MODE_BYTE, sla_pkg::BYTE_LF, 1'b1);
      add_item(MODE_TAKE, 8'h00, 1'b1);
      add_item(sla_pkg::MODE_BYTE, sla_pkg::BYTE_CR, 1'b1);
      add_item(sla_pkg::MODE_BYTE, 8'h43, 1'b1);
      add_item(sla_pkg::MODE_BYTE, sla_pkg::BYTE_LF, 1'b1);
      add_item(MODE_TAKE, 8'h00, 1'b1);
      add_item(MODE_TAKE, 8'h00, 1'b1);

      // longest line, then the shortest oversized one
      add_line(sla_pkg::MAX_LINE - 1, 0);
      add_item(MODE_TAKE, 8'($urandom_range(0, 255)), 1'b1);
      add_line(sla_pkg::MAX_LINE, 0);
      add_item(MODE_TAKE, 8'($urandom_range(0, 255)), 1'b1);

      while (counted < ITEM_TARGET) begin
         no_idle = ($urandom_range(0, 3) == 0);
         pick    = $urandom_range(0, 99);
         if (pick < 55) begin
            if ($urandom_range(0, 9) == 0)
               len = $urandom_range(0, 1) ? sla_pkg::MAX_LINE - 1 :
                     $urandom_range(40, sla_pkg::MAX_LINE - 1);
            else
               len = $urandom_range(0, 8);
            add_line(len, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
            if ($urandom_range(0, 9) < 7)
               add_item(MODE_TAKE, 8'($urandom_range(0, 255)), 1'b1);
         end else if (pick < 59) begin
            add_line(sla_pkg::MAX_LINE + $urandom_range(0, 3), $urandom_range(0, 1));
         end else if (pick < 75) begin
            add_item(MODE_TAKE, 8'($urandom_range(0, 255)), 1'b1);
         end else begin
            add_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b1);
         end
      end
      total_items = stim_q.size();

      repeat (11) @(negedge clock);
      reset <= 1'b0;
      while (sent < total_items)
         @(negedge clock);
      while (owed_rsp_q.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
      if (errors == 0)
         $display("serial_line_assembler: match");
      else
         $display("serial_line_assembler: mismatch");
      $finish;
   end

endmodule
